@@ design/nmst_pkg.sv @@
package nmst_pkg;

    localparam int NMST_STACK_DEPTH = 16;
    localparam int NMST_MODE_W      = 8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_OPEN = 2'd1,
        ST_FULL    = 2'd2
    } nmst_status_t;

    typedef enum logic {
        KIND_OPEN  = 1'b0,
        KIND_CLOSE = 1'b1
    } nmst_kind_t;

    typedef struct packed {
        logic         load;
        logic         push;
        logic         init_idx;
        logic         idx_dec;
        logic         idx_inc;
        logic         rd_idx;
        logic         rd_next;
        logic         rd_top;
        logic         shift_wr;
        logic         pop;
        logic         set_status;
        nmst_status_t status;
        logic         emit;
    } nmst_cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic count_zero;
        logic match;
        logic idx_zero;
        logic shift_more;
        logic out_free;
    } nmst_stat_t;

endpackage

@@ design/nmst_in_if.sv @@
interface nmst_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] mode_id;

    modport source (output valid, input ready, output kind, output mode_id);
    modport sink   (input valid, output ready, input kind, input mode_id);
endinterface

@@ design/nmst_out_if.sv @@
interface nmst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] current_mode;
    logic       at_start;
    logic [1:0] status;

    modport source (output valid, input ready, output current_mode, output at_start,
                    output status);
    modport sink   (input valid, output ready, input current_mode, input at_start,
                    input status);
endinterface

@@ design/nmst_ram.sv @@
module nmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ design/nmst_ctrl.sv @@
module nmst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nmst_pkg::nmst_stat_t st,
    output nmst_pkg::nmst_cmd_t  cmd
);
    import nmst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_CHK,
        S_SH_WR,
        S_TOP_RD,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.set_status = 1'b1;
                if (st.kind == KIND_OPEN)
                begin
                    if (st.full)
                    begin
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                    state_next = S_TOP_RD;
                end
                else if (st.count_zero)
                begin
                    cmd.status = ST_NO_OPEN;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    cmd.init_idx = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                priority if (st.match)
                begin
                    state_next = S_SH_CHK;
                end
                else if (st.idx_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_OPEN;
                    state_next     = S_TOP_RD;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SH_CHK:
            begin
                if (st.shift_more)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SH_WR;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_TOP_RD;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SH_CHK;
            end
            S_TOP_RD:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ design/nmst_dp.sv @@
module nmst_dp #(
    parameter int STACK_DEPTH = nmst_pkg::NMST_STACK_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 kind,
    input  logic [7:0]           mode_id,
    input  nmst_pkg::nmst_cmd_t  cmd,
    output nmst_pkg::nmst_stat_t st,
    nmst_out_if.source           result
);
    import nmst_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                   kind_reg;
    logic [NMST_MODE_W-1:0] mode_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          idx_next;
    nmst_status_t           status_reg;
    logic                   out_valid_reg;
    logic [NMST_MODE_W-1:0] out_mode_reg;
    logic                   out_start_reg;
    nmst_status_t           out_status_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [NMST_MODE_W-1:0] wdata;
    logic                   re;
    logic [AW-1:0]          raddr;
    logic [NMST_MODE_W-1:0] rdata;
    logic [CW-1:0]          count_m1;
    logic                   count_zero;

    assign count_m1   = count_reg - CW'(1);
    assign count_zero = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.init_idx)
        begin
            idx_next = AW'(count_m1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            kind_reg <= kind;
            mode_reg <= mode_id;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.emit)
        begin
            out_mode_reg   <= count_zero ? '0 : rdata;
            out_start_reg  <= count_zero;
            out_status_reg <= status_reg;
        end
    end

    always_comb
    begin
        we    = cmd.push | cmd.shift_wr;
        waddr = cmd.push ? AW'(count_reg) : idx_reg;
        wdata = cmd.push ? mode_reg : rdata;
        re    = cmd.rd_idx | cmd.rd_next | cmd.rd_top;
        priority if (cmd.rd_next)
        begin
            raddr = idx_reg + AW'(1);
        end
        else if (cmd.rd_top)
        begin
            raddr = AW'(count_m1);
        end
        else
        begin
            raddr = idx_reg;
        end
    end

    nmst_ram #(
        .WIDTH(NMST_MODE_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign st.kind       = kind_reg;
    assign st.full       = (count_reg == CW'(STACK_DEPTH));
    assign st.count_zero = count_zero;
    assign st.match      = (rdata == mode_reg);
    assign st.idx_zero   = (idx_reg == '0);
    assign st.shift_more = ((CW'(idx_reg) + CW'(1)) < count_reg);
    assign st.out_free   = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.current_mode = out_mode_reg;
    assign result.at_start     = out_start_reg;
    assign result.status       = out_status_reg;
endmodule

@@ design/nested_mode_stack_tracker.sv @@
// channel  dir  payload                          handshake
// item     in   kind, mode_id                    valid/ready
// result   out  current_mode, at_start, status   valid/ready
//
// One item at a time. Open, or close on an empty stack: decide, read the top
// entry, load the output register. Close: search from the top, a read and
// a compare per entry; on a match, shift each entry above it down one place
// through the single read and single write port of the stack RAM.
// Reset clears the entry count, output valid and control state; stack RAM contents are never cleared.
// A finished word sits in the output register; the next item is taken
// while it waits, and that item's result is held until the word is taken.
module nested_mode_stack_tracker #(
    parameter int STACK_DEPTH = nmst_pkg::NMST_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    nmst_in_if.sink   item,
    nmst_out_if.source result
);
    import nmst_pkg::*;

    nmst_cmd_t  cmd;
    nmst_stat_t st;
    logic       in_ready;

    assign item.ready = in_ready;

    nmst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(item.valid),
        .in_ready(in_ready),
        .st      (st),
        .cmd     (cmd)
    );

    nmst_dp #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .kind   (item.kind),
        .mode_id(item.mode_id),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item accepted while busy");

    a_full_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_FULL) |-> !result.at_start)
        else $error("full status with empty stack");

    a_start_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.at_start) |-> (result.current_mode == '0))
        else $error("start mode with nonzero mode");

    a_start_no_ok_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push) |=> !st.count_zero)
        else $error("push left stack empty");
endmodule
